FILE: rtl/max_heap_priority_queue_macros.svh
// Assertion macros shared by the checker of the max-heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mhpq_pkg.sv
// Types and constants shared by the max-heap priority queue modules.
`default_nettype none

package mhpq_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_RAW    = 2'd2;
    localparam logic [1:0] KIND_BUILD  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         job_id;
        logic signed [15:0] job_priority;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         removed_id;
        logic signed [15:0] removed_priority;
        logic               top_valid;
        logic [7:0]         top_id;
        logic signed [15:0] top_priority;
        logic [7:0]         job_count;
    } t_out_word;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] pri;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_LD,
        S_DN_RD,
        S_DN_CMP,
        S_BLD_NEXT,
        S_BLD_LD,
        S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_FULL,
        DP_EMPTY,
        DP_RAW,
        DP_INS,
        DP_DEL,
        DP_DEL_LD,
        DP_BLD,
        DP_BLD_STEP,
        DP_BLD_LD,
        DP_UP_RD,
        DP_UP_MOVE,
        DP_PUT_X,
        DP_DN_RD,
        DP_DN_MOVE,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       empty;
        logic       pos_zero;
        logic       bld_zero;
        logic       up_swap;
        logic       dn_move;
        logic       out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/mhpq_datapath.sv
// Datapath of the max-heap priority queue: slot memory, sift registers and result register.
`default_nettype none

module mhpq_datapath #(
    parameter int CAPACITY = 128
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mhpq_pkg::t_dp_cmd   i_cmd,
    output mhpq_pkg::t_dp_sts   o_sts,
    input  mhpq_pkg::t_in_word  i_in_word,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output mhpq_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    mhpq_pkg::t_job r_mem [CAPACITY];

    mhpq_pkg::t_job r_rd_a, r_rd_b;
    mhpq_pkg::t_job r_x, n_x;
    mhpq_pkg::t_job r_top;
    mhpq_pkg::t_job r_rem, n_rem;
    mhpq_pkg::t_job wr_data;

    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_bld, n_bld;
    logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic [AW-1:0] parent, cnt_m1;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_kind, n_kind;
    logic [1:0]    r_status, n_status;
    logic          wr_en;

    logic                r_out_valid, n_out_valid;
    mhpq_pkg::t_out_word r_out, n_out;

    logic [IW-1:0] left_idx, right_idx, count_ext;
    logic          left_ok, right_ok, pick_left, pick_right, out_free;

    // Children of the current position; two spare bits keep 2*pos+2 from wrapping.
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = {1'b0, r_pos, 1'b0} + IW'(2);
    assign count_ext = IW'(r_count);
    assign left_ok   = left_idx < count_ext;
    assign right_ok  = right_idx < count_ext;

    // The moving job sits in r_x; its slot is written only once it settles.
    assign pick_left  = left_ok && ($signed(r_rd_a.pri) > $signed(r_x.pri));
    assign pick_right = right_ok &&
        ($signed(r_rd_b.pri) > (pick_left ? $signed(r_rd_a.pri) : $signed(r_x.pri)));

    assign parent   = (r_pos - AW'(1)) >> 1;
    assign cnt_m1   = AW'(r_count - CW'(1));
    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.kind     = r_kind;
    assign o_sts.full     = r_count == CW'(CAPACITY);
    assign o_sts.empty    = r_count == '0;
    assign o_sts.pos_zero = r_pos == '0;
    assign o_sts.bld_zero = r_bld == '0;
    assign o_sts.up_swap  = $signed(r_rd_a.pri) < $signed(r_x.pri);
    assign o_sts.dn_move  = pick_left || pick_right;
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_x         = r_x;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_bld       = r_bld;
        n_count     = r_count;
        n_kind      = r_kind;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_addr_a   = '0;
        rd_addr_b   = '0;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_x;
        case (i_cmd.op)
            mhpq_pkg::DP_LOAD: begin
                n_kind     = i_in_word.kind;
                n_x.id     = i_in_word.job_id;
                n_x.pri    = i_in_word.job_priority;
                n_status   = mhpq_pkg::ST_DONE;
                n_rem      = '0;
            end
            mhpq_pkg::DP_FULL: begin
                n_status = mhpq_pkg::ST_OVERFLOW;
            end
            mhpq_pkg::DP_EMPTY: begin
                n_status = mhpq_pkg::ST_EMPTY;
            end
            mhpq_pkg::DP_RAW: begin
                wr_en   = 1'b1;
                wr_addr = r_count[AW-1:0];
                n_count = r_count + CW'(1);
            end
            mhpq_pkg::DP_INS: begin
                n_pos   = r_count[AW-1:0];
                n_count = r_count + CW'(1);
            end
            mhpq_pkg::DP_DEL: begin
                n_rem     = r_top;
                rd_addr_a = cnt_m1;
            end
            mhpq_pkg::DP_DEL_LD: begin
                n_x     = r_rd_a;
                n_count = r_count - CW'(1);
                n_pos   = '0;
            end
            mhpq_pkg::DP_BLD: begin
                n_bld = AW'(r_count >> 1);
            end
            mhpq_pkg::DP_BLD_STEP: begin
                n_bld     = r_bld - AW'(1);
                rd_addr_a = r_bld - AW'(1);
            end
            mhpq_pkg::DP_BLD_LD: begin
                n_x   = r_rd_a;
                n_pos = r_bld;
            end
            mhpq_pkg::DP_UP_RD: begin
                rd_addr_a = parent;
            end
            mhpq_pkg::DP_UP_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rd_a;
                n_pos   = parent;
            end
            mhpq_pkg::DP_PUT_X: begin
                wr_en = 1'b1;
            end
            mhpq_pkg::DP_DN_RD: begin
                rd_addr_a = left_idx[AW-1:0];
                rd_addr_b = right_idx[AW-1:0];
            end
            mhpq_pkg::DP_DN_MOVE: begin
                wr_en = 1'b1;
                if (pick_right) begin
                    wr_data = r_rd_b;
                    n_pos   = right_idx[AW-1:0];
                end else begin
                    wr_data = r_rd_a;
                    n_pos   = left_idx[AW-1:0];
                end
            end
            mhpq_pkg::DP_OUT: begin
                n_out_valid            = 1'b1;
                n_out.status           = r_status;
                n_out.removed_id       = r_rem.id;
                n_out.removed_priority = r_rem.pri;
                n_out.top_valid        = r_count != '0;
                n_out.top_id           = (r_count != '0) ? r_top.id : 8'd0;
                n_out.top_priority     = (r_count != '0) ? r_top.pri : 16'sd0;
                n_out.job_count        = 8'(r_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Copy of slot zero, kept so the root is at hand without a memory read.
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == '0) begin
            r_top <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_rem    <= n_rem;
        r_pos    <= n_pos;
        r_bld    <= n_bld;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire

FILE: rtl/mhpq_ctrl.sv
// Controller state machine of the max-heap priority queue.
`default_nettype none

module mhpq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  mhpq_pkg::t_dp_sts i_sts,
    output mhpq_pkg::t_dp_cmd o_cmd
);

    mhpq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = mhpq_pkg::DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            mhpq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = mhpq_pkg::DP_LOAD;
                    n_state  = mhpq_pkg::S_DISPATCH;
                end
            end
            mhpq_pkg::S_DISPATCH: begin
                if (i_sts.kind inside {mhpq_pkg::KIND_INSERT, mhpq_pkg::KIND_RAW}) begin
                    if (i_sts.full) begin
                        o_cmd.op = mhpq_pkg::DP_FULL;
                        n_state  = mhpq_pkg::S_FINISH;
                    end else if (i_sts.kind == mhpq_pkg::KIND_RAW) begin
                        o_cmd.op = mhpq_pkg::DP_RAW;
                        n_state  = mhpq_pkg::S_FINISH;
                    end else begin
                        o_cmd.op = mhpq_pkg::DP_INS;
                        n_state  = mhpq_pkg::S_UP_RD;
                    end
                end else if (i_sts.kind == mhpq_pkg::KIND_DELETE) begin
                    if (i_sts.empty) begin
                        o_cmd.op = mhpq_pkg::DP_EMPTY;
                        n_state  = mhpq_pkg::S_FINISH;
                    end else begin
                        o_cmd.op = mhpq_pkg::DP_DEL;
                        n_state  = mhpq_pkg::S_DEL_LD;
                    end
                end else begin
                    o_cmd.op = mhpq_pkg::DP_BLD;
                    n_state  = mhpq_pkg::S_BLD_NEXT;
                end
            end
            mhpq_pkg::S_UP_RD: begin
                if (i_sts.pos_zero) begin
                    o_cmd.op = mhpq_pkg::DP_PUT_X;
                    n_state  = mhpq_pkg::S_FINISH;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_UP_RD;
                    n_state  = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                if (i_sts.up_swap) begin
                    o_cmd.op = mhpq_pkg::DP_UP_MOVE;
                    n_state  = mhpq_pkg::S_UP_RD;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_PUT_X;
                    n_state  = mhpq_pkg::S_FINISH;
                end
            end
            mhpq_pkg::S_DEL_LD: begin
                o_cmd.op = mhpq_pkg::DP_DEL_LD;
                n_state  = mhpq_pkg::S_DN_RD;
            end
            mhpq_pkg::S_DN_RD: begin
                o_cmd.op = mhpq_pkg::DP_DN_RD;
                n_state  = mhpq_pkg::S_DN_CMP;
            end
            mhpq_pkg::S_DN_CMP: begin
                if (i_sts.dn_move) begin
                    o_cmd.op = mhpq_pkg::DP_DN_MOVE;
                    n_state  = mhpq_pkg::S_DN_RD;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_PUT_X;
                    // A build goes on with the next internal node.
                    n_state  = (i_sts.kind == mhpq_pkg::KIND_BUILD) ?
                               mhpq_pkg::S_BLD_NEXT : mhpq_pkg::S_FINISH;
                end
            end
            mhpq_pkg::S_BLD_NEXT: begin
                if (i_sts.bld_zero) begin
                    n_state = mhpq_pkg::S_FINISH;
                end else begin
                    o_cmd.op = mhpq_pkg::DP_BLD_STEP;
                    n_state  = mhpq_pkg::S_BLD_LD;
                end
            end
            mhpq_pkg::S_BLD_LD: begin
                o_cmd.op = mhpq_pkg::DP_BLD_LD;
                n_state  = mhpq_pkg::S_DN_RD;
            end
            mhpq_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mhpq_pkg::DP_OUT;
                    n_state  = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: controller, datapath and the two word channels.
// Each input word is one operation on a binary max-heap of up to CAPACITY jobs held in a
// single slot memory with two registered read ports and one write port, and yields one
// output word. The block works on one word at a time; the next word is taken once the
// result sits in the output register, even if that word has not been collected yet.
// For each level that the moving job crosses there is a read step, which reads the parent or
// both children, and a compare step, which compares and writes the slot; a build sifts each
// internal node down in turn, from the last one to the root. A finished word whose predecessor
// still waits in the output register holds the block until that word is collected.
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  mhpq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output mhpq_pkg::t_out_word o_out_word
);

    mhpq_pkg::t_dp_cmd dp_cmd;
    mhpq_pkg::t_dp_sts dp_sts;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

FILE: rtl/mhpq_checker.sv
// Port-level checker of the max-heap priority queue and its bind to the top level.
`default_nettype none

`include "max_heap_priority_queue_macros.svh"

module mhpq_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 i_in_ready,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input mhpq_pkg::t_out_word i_out_word
);

    `MHPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word), "output word changed or dropped while stalled")

    // One word is worked on at a time, so an accepted word closes the input side.
    `MHPQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input still ready right after a word was accepted")

    `MHPQ_ASSERT_NOW(a_empty_top, i_clk, i_rst_n, i_out_valid && !i_out_word.top_valid, i_out_word.top_id == 8'd0 && i_out_word.top_priority == 16'sd0 && i_out_word.job_count == 8'd0, "empty heap reported a root job or a count")

    `MHPQ_ASSERT_NOW(a_fail_no_removal, i_clk, i_rst_n, i_out_valid && i_out_word.status != mhpq_pkg::ST_DONE, i_out_word.removed_id == 8'd0 && i_out_word.removed_priority == 16'sd0, "failed operation reported a removed job")

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);

`default_nettype wire

FILE: verif/max_heap_priority_queue_tb.sv
// Self-checking testbench for the max-heap priority queue with a scoreboard-based heap predictor.
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;

    localparam int CAPACITY    = 128;
    localparam int RANDOM_OPS  = 1850;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 40;

    typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} t_phase;

    class heap_tracker;
        mhpq_pkg::t_job      slots [CAPACITY];
        int                  count;
        mhpq_pkg::t_out_word pending_words [$];
        int                  mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function void swap_slots(int a, int b);
            mhpq_pkg::t_job tmp;
            tmp      = slots[a];
            slots[a] = slots[b];
            slots[b] = tmp;
        endfunction

        // A swap needs a strictly greater child; the left child wins ties.
        function void sift_down(int pos);
            int best;
            int l;
            int r;
            bit moving;
            moving = 1'b1;
            while (moving) begin
                best = pos;
                l    = 2 * pos + 1;
                r    = 2 * pos + 2;
                if (l < count && $signed(slots[l].pri) > $signed(slots[best].pri)) best = l;
                if (r < count && $signed(slots[r].pri) > $signed(slots[best].pri)) best = r;
                if (best == pos) begin
                    moving = 1'b0;
                end else begin
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        endfunction

        function void sift_up(int pos);
            int parent;
            while (pos != 0) begin
                parent = (pos - 1) / 2;
                if ($signed(slots[parent].pri) < $signed(slots[pos].pri)) begin
                    swap_slots(pos, parent);
                    pos = parent;
                end else begin
                    pos = 0;
                end
            end
        endfunction

        function void note_op(mhpq_pkg::t_in_word w);
            mhpq_pkg::t_out_word res;
            int                  i;
            res        = '0;
            res.status = mhpq_pkg::ST_DONE;
            case (w.kind)
                mhpq_pkg::KIND_INSERT, mhpq_pkg::KIND_RAW: begin
                    if (count >= CAPACITY) begin
                        res.status = mhpq_pkg::ST_OVERFLOW;
                    end else begin
                        slots[count].id  = w.job_id;
                        slots[count].pri = w.job_priority;
                        count++;
                        if (w.kind == mhpq_pkg::KIND_INSERT) sift_up(count - 1);
                    end
                end
                mhpq_pkg::KIND_DELETE: begin
                    if (count == 0) begin
                        res.status = mhpq_pkg::ST_EMPTY;
                    end else begin
                        res.removed_id       = slots[0].id;
                        res.removed_priority = slots[0].pri;
                        slots[0]             = slots[count - 1];
                        count--;
                        sift_down(0);
                    end
                end
                default: begin
                    i = count / 2;
                    while (i > 0) begin
                        i--;
                        sift_down(i);
                    end
                end
            endcase
            if (count > 0) begin
                res.top_valid    = 1'b1;
                res.top_id       = slots[0].id;
                res.top_priority = slots[0].pri;
            end
            res.job_count = 8'(count);
            pending_words.push_back(res);
        endfunction

        function void check_word(mhpq_pkg::t_out_word got);
            mhpq_pkg::t_out_word want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("output word with nothing pending: %h", got);
                return;
            end
            want = pending_words.pop_front();
            if (got.status !== want.status || got.removed_id !== want.removed_id ||
                got.removed_priority !== want.removed_priority ||
                got.top_valid !== want.top_valid || got.top_id !== want.top_id ||
                got.top_priority !== want.top_priority || got.job_count !== want.job_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("expected st=%0d rm=%0d:%0d top=%0b:%0d:%0d n=%0d",
                             want.status, want.removed_id, want.removed_priority,
                             want.top_valid, want.top_id, want.top_priority, want.job_count);
                    $display("actual   st=%0d rm=%0d:%0d top=%0b:%0d:%0d n=%0d",
                             got.status, got.removed_id, got.removed_priority,
                             got.top_valid, got.top_id, got.top_priority, got.job_count);
                end
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    mhpq_pkg::t_in_word  i_in_word   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    mhpq_pkg::t_out_word o_out_word;

    heap_tracker tracker = new();
    int          burst_left = 0;

    max_heap_priority_queue #(.CAPACITY(CAPACITY)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Presents one word, waits for it to be taken, then maybe opens a gap before the next burst.
    task automatic send_word(input mhpq_pkg::t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_op(w);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            i_in_word  <= mhpq_pkg::t_in_word'(26'($urandom));
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
    endtask

    task automatic issue(input logic [1:0] kind, input logic [7:0] id, input logic [15:0] pri);
        mhpq_pkg::t_in_word w;
        w.kind         = kind;
        w.job_id       = id;
        w.job_priority = pri;
        send_word(w);
    endtask

    // Small values make ties common, which exercises the strict comparisons.
    function automatic logic [15:0] pick_priority();
        case ($urandom_range(0, 7))
            0, 1:    return 16'($urandom_range(0, 8) - 4);
            2:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_kind(t_phase phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_FILL: begin
                if (roll < 45) return mhpq_pkg::KIND_INSERT;
                if (roll < 85) return mhpq_pkg::KIND_RAW;
                if (roll < 95) return mhpq_pkg::KIND_DELETE;
                return mhpq_pkg::KIND_BUILD;
            end
            PH_DRAIN: begin
                if (roll < 7)  return mhpq_pkg::KIND_INSERT;
                if (roll < 11) return mhpq_pkg::KIND_RAW;
                if (roll < 96) return mhpq_pkg::KIND_DELETE;
                return mhpq_pkg::KIND_BUILD;
            end
            default: begin
                if (roll < 35) return mhpq_pkg::KIND_INSERT;
                if (roll < 60) return mhpq_pkg::KIND_RAW;
                if (roll < 90) return mhpq_pkg::KIND_DELETE;
                return mhpq_pkg::KIND_BUILD;
            end
        endcase
    endfunction

    initial begin
        int     done_ops;
        int     span;
        int     step;
        t_phase phase;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty delete and builds on an empty or single-entry heap must change nothing.
        issue(mhpq_pkg::KIND_DELETE, 8'hFF, 16'h7FFF);
        issue(mhpq_pkg::KIND_BUILD,  8'hFF, 16'h8000);
        issue(mhpq_pkg::KIND_INSERT, 8'h00, 16'h8000);
        issue(mhpq_pkg::KIND_BUILD,  8'h00, 16'h0000);
        issue(mhpq_pkg::KIND_INSERT, 8'hFF, 16'h7FFF);
        issue(mhpq_pkg::KIND_INSERT, 8'h5A, 16'h0000);
        // Equal to the root: must stay a child.
        issue(mhpq_pkg::KIND_INSERT, 8'hA5, 16'h7FFF);
        issue(mhpq_pkg::KIND_INSERT, 8'h01, 16'hFFFF);
        issue(mhpq_pkg::KIND_DELETE, 8'h00, 16'h0000);
        issue(mhpq_pkg::KIND_DELETE, 8'hFF, 16'hFFFF);
        // Raw loads leave the array out of order until the build; equal children test tie order.
        issue(mhpq_pkg::KIND_RAW, 8'h0A, 16'hFF9C);
        issue(mhpq_pkg::KIND_RAW, 8'h0B, 16'd500);
        issue(mhpq_pkg::KIND_RAW, 8'h0C, 16'd500);
        issue(mhpq_pkg::KIND_RAW, 8'h0D, 16'h7FFF);
        issue(mhpq_pkg::KIND_RAW, 8'h0E, 16'h8000);
        issue(mhpq_pkg::KIND_BUILD, 8'hAA, 16'h5555);
        repeat (9) issue(mhpq_pkg::KIND_DELETE, 8'($urandom), 16'($urandom));

        done_ops = 0;
        step     = 0;
        phase    = PH_FILL;
        while (done_ops < RANDOM_OPS) begin
            span = (phase == PH_MIXED) ? $urandom_range(60, 200) : $urandom_range(180, 260);
            if (span > RANDOM_OPS - done_ops) span = RANDOM_OPS - done_ops;
            repeat (span) issue(pick_kind(phase), 8'($urandom), pick_priority());
            done_ops += span;
            step++;
            case (step % 4)
                0:       phase = PH_FILL;
                2:       phase = PH_DRAIN;
                default: phase = PH_MIXED;
            endcase
        end
        i_in_valid <= 1'b0;

        while (tracker.pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Output side: checks each collected word and changes its stall pattern now and then.
    initial begin
        int mode;
        int mode_left;
        bit rdy;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) tracker.check_word(o_out_word);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 3) != 0);
                2:       rdy = ($urandom_range(0, 9) < 3);
                default: rdy = ($urandom_range(0, 31) == 0);
            endcase
            i_out_ready <= rdy;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
